>>> hdl/crest_factor_meter_macros.svh
// Assertion macros for the crest factor meter.
// Define NO_ASSERTIONS to compile them out.
`ifndef CREST_FACTOR_METER_MACROS_SVH
`define CREST_FACTOR_METER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CFM_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define CFM_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`else
`define CFM_ASSERT_IMP(label, clk, rst, a, c)
`define CFM_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

>>> hdl/cfm_pkg.sv
// Types and constants shared by the crest factor meter files.
// No dependencies.
package cfm_pkg;
  // Window length in frames; the mean is taken by a shift, so it stays a power of two
  localparam int WINDOW = 4096;
  localparam logic [15:0] DECAY_RESET = 16'd65470;
  localparam logic [22:0] CREST_K = 23'd6313057;
  localparam int CREST_LIMIT = 1600;
  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RD    = 9'b000000100,
    S_SUM   = 9'b000001000,
    S_SQRT  = 9'b000010000,
    S_NORM  = 9'b000100000,
    S_LOG   = 9'b001000000,
    S_MUL   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;
endpackage

>>> hdl/cfm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module cfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> hdl/crest_factor_meter.sv
// Crest factor meter top level: peak, windowed RMS and crest in 1/16 dB.
// Depends on cfm_pkg, cfm_ram and crest_factor_meter_macros.svh.
// Steps: input capture, ring read, sum update, SAMPLE_BITS+6 sqrt steps,
// two 16-step log2 passes on the shared multiplier, then the crest multiply.
// One frame at a time: input stalled until the result is taken with no output stall.
// Reset: after rst a clearing pass of WINDOW cycles zeroes the ring store.
`include "crest_factor_meter_macros.svh"
module crest_factor_meter #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [23:0]                   peak_level,
  output logic [23:0]                   rms_level,
  output logic signed [11:0]            crest_db,
  output logic                          silent,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [15:0]                   cfg_data
);
  import cfm_pkg::*;
  localparam int SB = SAMPLE_BITS;
  localparam int MSW = 2 * SB - 2;
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUMW = MSW + AW + 1;
  localparam int WSH = $clog2(WINDOW);
  localparam int MEANW = SUMW + (SUMW % 2);  // even, so the sqrt takes whole bit pairs
  localparam int RW = MEANW / 2;
  localparam int PW = SB + 1;
  localparam int LW = 8 + 16;
  localparam int SQ_ITER = RW;

  state_t state;
  logic [15:0] decay;
  logic [AW-1:0] ptr;
  logic [AW:0] clr_cnt;
  logic [SUMW-1:0] sum;
  logic [PW-1:0] peak, mag_max;
  logic [MSW-1:0] msq;
  logic [MSW-1:0] ring_wd;
  logic ring_we;
  logic [MSW-1:0] ring_rd;
  logic [AW-1:0] ring_addr;
  logic [MEANW+1:0] sq_rem;
  logic [RW-1:0] sq_res;
  logic [MEANW-1:0] sq_val;
  logic [5:0] cnt;
  logic phase;          // 0: log of peak, 1: log of rms
  logic [31:0] mant;    // Q1.30
  logic [15:0] frac;
  logic [7:0] expo;
  logic signed [LW:0] log_p;
  logic signed [LW:0] dlog;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [PW-1:0] lg_x;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);

  // Input magnitudes and mean square
  logic [SB-1:0] al, ar;
  logic [2*SB:0] sqs;
  always_comb begin
    al = left_sample[SB-1] ? SB'(-left_sample) : SB'(left_sample);
    ar = right_sample[SB-1] ? SB'(-right_sample) : SB'(right_sample);
    sqs = ((2*SB+1)'(al) * (2*SB+1)'(al) + (2*SB+1)'(ar) * (2*SB+1)'(ar)) >> 1;
  end

  // Shared multiplier
  assign mul_p = mul_a * mul_b;
  always_comb begin
    mul_a = 33'(peak);
    mul_b = 33'(decay);
    if (state == S_LOG) begin
      mul_a = 33'(mant);
      mul_b = 33'(mant);
    end else if (state == S_MUL) begin
      mul_a = 33'(dlog);
      mul_b = 33'(CREST_K);
    end
  end

  assign ring_addr = (state == S_CLEAR) ? clr_cnt[AW-1:0] : ptr;
  assign ring_we = (state == S_CLEAR) || (state == S_SUM);
  assign ring_wd = (state == S_CLEAR) ? '0 : msq;

  cfm_ram #(.WIDTH(MSW), .DEPTH(WINDOW)) u_ring (
    .clk(clk), .we(ring_we), .addr(ring_addr), .wdata(ring_wd),
    .rdata(ring_rd)
  );

  // Sqrt step
  logic [MEANW+1:0] trial;
  logic [1:0] pair;
  logic [MEANW+1:0] rem_sh;
  always_comb begin
    pair = sq_val[MEANW-1 -: 2];
    rem_sh = {sq_rem[MEANW-1:0], pair};
    trial = {{(MEANW-RW){1'b0}}, sq_res, 2'b01};
  end

  // log2 normalisation
  logic [7:0] msb;
  always_comb begin
    msb = '0;
    for (int i = 0; i < PW; i++) if (lg_x[i]) msb = 8'(i);
  end

  logic [32:0] msq_m;
  assign msq_m = 33'(mul_p >> 30);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      decay <= DECAY_RESET;
      clr_cnt <= '0;
      ptr <= '0;
      sum <= '0;
      peak <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) decay <= cfg_data;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(WINDOW - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            mag_max <= (al > ar) ? PW'(al) : PW'(ar);
            msq <= (sqs > (2*SB+1)'({MSW{1'b1}})) ? {MSW{1'b1}} : sqs[MSW-1:0];
            state <= S_RD;
          end
        end
        S_RD: begin
          // ram read of old entry lands next cycle; peak update meanwhile
          peak <= (PW'(mul_p >> 16) > mag_max) ? PW'(mul_p >> 16) : mag_max;
          state <= S_SUM;
        end
        S_SUM: begin
          sum <= sum - SUMW'(ring_rd) + SUMW'(msq);
          ptr <= (ptr == AW'(WINDOW - 1)) ? '0 : ptr + 1'b1;
          sq_val <= MEANW'((sum - SUMW'(ring_rd) + SUMW'(msq)) >> WSH);
          sq_rem <= '0;
          sq_res <= '0;
          cnt <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          sq_val <= sq_val << 2;
          if (rem_sh >= trial) begin
            sq_rem <= rem_sh - trial;
            sq_res <= {sq_res[RW-2:0], 1'b1};
          end else begin
            sq_rem <= rem_sh;
            sq_res <= {sq_res[RW-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'(SQ_ITER - 1)) begin
            phase <= 1'b0;
            lg_x <= peak;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          expo <= msb;
          mant <= 32'(64'(lg_x) << 30 >> msb);
          frac <= '0;
          cnt <= '0;
          state <= S_LOG;
        end
        S_LOG: begin
          if (msq_m[31]) begin
            mant <= msq_m[32:1];
            frac <= {frac[14:0], 1'b1};
          end else begin
            mant <= msq_m[31:0];
            frac <= {frac[14:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'd15) begin
            if (!phase) begin
              log_p <= (LW+1)'({expo, (msq_m[31] ? {frac[14:0], 1'b1}
                                                 : {frac[14:0], 1'b0})});
              phase <= 1'b1;
              lg_x <= PW'(sq_res);
              state <= S_NORM;
            end else begin
              dlog <= log_p - (LW+1)'({expo, (msq_m[31] ? {frac[14:0], 1'b1}
                                                        : {frac[14:0], 1'b0})});
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          begin : crest_blk
            logic signed [63:0] c;
            c = 64'((mul_p + 66'sd2147483648) >>> 32);
            if (sq_res == '0) crest_db <= 12'(CREST_LIMIT);
            else if (peak == '0) crest_db <= -12'(CREST_LIMIT);
            else if (c > 64'(CREST_LIMIT)) crest_db <= 12'(CREST_LIMIT);
            else if (c < -64'(CREST_LIMIT)) crest_db <= -12'(CREST_LIMIT);
            else crest_db <= 12'(c);
          end
          peak_level <= 24'(peak);
          rms_level <= 24'(sq_res);
          silent <= (sq_res == '0);
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  `CFM_ASSERT_IMP(a_out_state, clk, rst, out_valid, state == S_OUT)
  `CFM_ASSERT_IMP(a_no_accept_busy, clk, rst, state != S_IDLE, in_stall)
  `CFM_ASSERT_NXT(a_accept_rd, clk, rst, in_valid && !in_stall, state == S_RD)
endmodule
